[rtl/pcmdb_pkg.sv]
// ----------------------------------------------------------------------------
// pcmdb_pkg: shared types and constants of the PCM block level meter
// Beat layouts, sizing of the accumulators and the dB threshold table.
// ----------------------------------------------------------------------------
package pcmdb_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    // |sample| <= 2^15, so the sum stays below 2^(15 + CNT_W)
    localparam int SUM_W       = 15 + CNT_W;
    localparam int MEAN_W      = 16;
    localparam int STEP_W      = $clog2(SUM_W);
    localparam int UNIT_W      = ((CNT_W + 1 > MEAN_W) ? CNT_W + 1 : MEAN_W) + 1;

    localparam int TABLE_LEN   = 90;
    localparam int IDX_W       = $clog2(TABLE_LEN + 1);
    localparam int EDGE_W      = 15;

    localparam logic signed [7:0] LEVEL_FLOOR   = -8'sd96;
    localparam logic signed [7:0] LOUD_DB_RESET = -8'sd40;

    // Entry i is the smallest mean whose level is above i-96 dB
    localparam logic [EDGE_W-1:0] LEVEL_EDGE [TABLE_LEN] = '{
        15'd2,     15'd2,     15'd2,     15'd2,     15'd2,
        15'd2,     15'd3,     15'd3,     15'd3,     15'd3,
        15'd4,     15'd4,     15'd5,     15'd5,     15'd6,
        15'd6,     15'd7,     15'd8,     15'd9,     15'd10,
        15'd11,    15'd12,    15'd14,    15'd15,    15'd17,
        15'd19,    15'd21,    15'd24,    15'd27,    15'd30,
        15'd33,    15'd37,    15'd42,    15'd47,    15'd53,
        15'd59,    15'd66,    15'd74,    15'd83,    15'd93,
        15'd104,   15'd117,   15'd131,   15'd147,   15'd165,
        15'd185,   15'd208,   15'd233,   15'd261,   15'd293,
        15'd329,   15'd369,   15'd414,   15'd464,   15'd521,
        15'd585,   15'd656,   15'd736,   15'd826,   15'd926,
        15'd1039,  15'd1166,  15'd1308,  15'd1468,  15'd1647,
        15'd1848,  15'd2073,  15'd2326,  15'd2609,  15'd2928,
        15'd3285,  15'd3686,  15'd4135,  15'd4640,  15'd5206,
        15'd5841,  15'd6554,  15'd7354,  15'd8251,  15'd9258,
        15'd10387, 15'd11654, 15'd13076, 15'd14672, 15'd16462,
        15'd18471, 15'd20724, 15'd23253, 15'd26090, 15'd29274
    };

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } t_in_beat;

    typedef struct packed {
        logic signed [7:0] level_db;
        logic              loud;
        logic              overflow;
    } t_out_beat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SEARCH,
        S_DONE
    } t_lvl_state;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic signed [7:0] level_db;
    } t_lvl_stat;

    function automatic logic [EDGE_W-1:0] edge_of(input logic [IDX_W-1:0] idx);
        logic [EDGE_W-1:0] val;
        val = '1;
        if (idx < IDX_W'(TABLE_LEN)) begin
            val = LEVEL_EDGE[idx];
        end
        return val;
    endfunction

endpackage

[rtl/pcm_block_level_db_meter.sv]
// ----------------------------------------------------------------------------
// pcm_block_level_db_meter: mean absolute level of a PCM block in whole dB
// A sample that is not last is summed when taken, up to MAX_SAMPLES per block.
// A last sample stalls the input while the level unit divides the sum by
// the count, searches the threshold table and waits for the hand-off.
// The result beat appears in the output register right after that.
// Reset (synchronous, active low) clears the accumulators and the output
// valid, and loads the loud threshold with -40 dB.
// ----------------------------------------------------------------------------
module pcm_block_level_db_meter import pcmdb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_beat    i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_beat   o_out_data,
    input  logic        i_out_stall,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data
);

    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_ovf, n_ovf;
    logic              r_blk_ovf;
    logic signed [7:0] r_loud_db;
    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out_data;

    t_lvl_stat         stat;
    logic              in_acc;
    logic              start;
    logic              room;
    logic [15:0]       mag;
    logic [SUM_W-1:0]  sum_add;
    logic [CNT_W-1:0]  cnt_add;
    logic              ovf_add;
    logic              load;

    assign o_in_stall = stat.busy;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign start      = in_acc && i_in_data.last;

    assign mag     = i_in_data.sample[15] ? 16'(-i_in_data.sample) : i_in_data.sample;
    assign room    = r_cnt < CNT_W'(MAX_SAMPLES);
    assign sum_add = room ? r_sum + SUM_W'(mag) : r_sum;
    assign cnt_add = room ? r_cnt + 1'b1 : r_cnt;
    assign ovf_add = r_ovf || !room;

    // clear the accumulators when the last sample of a block is taken
    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (in_acc) begin
            n_sum = start ? '0   : sum_add;
            n_cnt = start ? '0   : cnt_add;
            n_ovf = start ? 1'b0 : ovf_add;
        end
    end

    pcmdb_level_unit u_level (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sum   (sum_add),
        .i_count (cnt_add),
        .i_ack   (load),
        .o_stat  (stat)
    );

    // take the result only when the output register is free this cycle
    assign load = stat.done && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_loud_db   <= LOUD_DB_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_loud_db <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_blk_ovf <= ovf_add;
        end
        if (load) begin
            r_out_data.level_db <= stat.level_db;
            r_out_data.loud     <= stat.level_db > r_loud_db;
            r_out_data.overflow <= r_blk_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[rtl/pcmdb_level_unit.sv]
// ----------------------------------------------------------------------------
// pcmdb_level_unit: mean and dB level of one finished block
// Restoring divide, one quotient bit a cycle, then a binary search of the
// threshold table; both run on one shared subtract/compare unit.
// ----------------------------------------------------------------------------
module pcmdb_level_unit import pcmdb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_sum,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_ack,
    output t_lvl_stat        o_stat
);

    t_lvl_state r_state, n_state;

    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_div, n_div;
    logic [STEP_W-1:0] r_step, n_step;
    logic [IDX_W-1:0]  r_lo, n_lo;
    logic [IDX_W-1:0]  r_hi, n_hi;

    logic              sel_div;
    logic [CNT_W:0]    rem_sh;
    logic [IDX_W:0]    mid_sum;
    logic [IDX_W-1:0]  mid;
    logic [UNIT_W-1:0] op_a, op_b, diff;
    logic              ge;

    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[IDX_W:1];

    // shared unit: divide step or table compare
    always_comb begin
        if (sel_div) begin
            op_a = UNIT_W'(rem_sh);
            op_b = UNIT_W'(r_div);
        end else begin
            op_a = UNIT_W'(r_quo[MEAN_W-1:0]);
            op_b = UNIT_W'(edge_of(mid));
        end
        diff = op_a - op_b;
        ge   = ~diff[UNIT_W-1];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_DIV;
            end
            S_DIV: begin
                if (r_step == STEP_W'(SUM_W - 1)) n_state = S_SEARCH;
            end
            S_SEARCH: begin
                if (r_lo == r_hi) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_ack) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        sel_div         = 1'b0;
        o_stat.busy     = 1'b1;
        o_stat.done     = 1'b0;
        o_stat.level_db = LEVEL_FLOOR + 8'({1'b0, r_lo});
        case (r_state)
            S_IDLE:   o_stat.busy = 1'b0;
            S_DIV:    sel_div     = 1'b1;
            S_SEARCH: sel_div     = 1'b0;
            S_DONE:   o_stat.done = 1'b1;
            default:  o_stat.busy = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        n_step = r_step;
        n_lo   = r_lo;
        n_hi   = r_hi;
        case (r_state)
            S_IDLE: begin
                n_quo  = i_sum;
                n_rem  = '0;
                n_div  = i_count;
                n_step = '0;
                n_lo   = '0;
                n_hi   = IDX_W'(TABLE_LEN);
            end
            S_DIV: begin
                n_quo  = {r_quo[SUM_W-2:0], ge};
                n_rem  = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                n_step = r_step + 1'b1;
            end
            S_SEARCH: begin
                // narrow to the first entry above the mean
                if (r_lo != r_hi) begin
                    if (ge) n_lo = mid + 1'b1;
                    else    n_hi = mid;
                end
            end
            S_DONE: begin
                n_quo = r_quo;
            end
            default: begin
                n_quo = r_quo;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_step <= n_step;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
    end

endmodule

[test/tb_pcm_block_level_db_meter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pcm_block_level_db_meter: block level meter testbench
// Drives blocks of PCM samples and predicts the level, loud and overflow
// flags of each block. Every result beat is checked against that prediction.
// Directed edge cases come first. Random blocks follow under several loud
// thresholds, with random idling on both sides, one long output hold-off,
// and a clean run at the end.
// ----------------------------------------------------------------------------
module tb_pcm_block_level_db_meter;
    import pcmdb_pkg::*;

    class level_tracker;
        logic signed [7:0] loud_db;
        logic [27:0]       abs_sum;
        int unsigned       n_summed;
        bit                too_long;
        int unsigned       db_edges[90];
        t_out_beat         levels_due[$];
        int                errors;

        function new();
            loud_db  = -8'sd40;
            abs_sum  = '0;
            n_summed = 0;
            too_long = 1'b0;
            errors   = 0;
            // smallest mean whose level is above (index - 96) dB
            db_edges = '{
                2, 2, 2, 2, 2, 2, 3, 3, 3, 3,
                4, 4, 5, 5, 6, 6, 7, 8, 9, 10,
                11, 12, 14, 15, 17, 19, 21, 24, 27, 30,
                33, 37, 42, 47, 53, 59, 66, 74, 83, 93,
                104, 117, 131, 147, 165, 185, 208, 233, 261, 293,
                329, 369, 414, 464, 521, 585, 656, 736, 826, 926,
                1039, 1166, 1308, 1468, 1647, 1848, 2073, 2326, 2609, 2928,
                3285, 3686, 4135, 4640, 5206, 5841, 6554, 7354, 8251, 9258,
                10387, 11654, 13076, 14672, 16462, 18471, 20724, 23253, 26090, 29274
            };
        endfunction

        // a mean of 0 or 1 passes no edge and stays at the floor
        function int level_of(int unsigned mean);
            int lvl;
            lvl = -96;
            foreach (db_edges[i]) begin
                if (mean >= db_edges[i]) lvl++;
            end
            return lvl;
        endfunction

        function void take_sample(t_in_beat b);
            int          s;
            int unsigned mean;
            int          lvl;
            t_out_beat   want;
            s = b.sample;
            // drop samples past the cap, the last one too
            if (n_summed < MAX_SAMPLES) begin
                abs_sum += (s < 0) ? -s : s;
                n_summed++;
            end else begin
                too_long = 1'b1;
            end
            if (!b.last) return;
            mean          = (n_summed != 0) ? abs_sum / n_summed : 0;
            lvl           = level_of(mean);
            want.level_db = lvl[7:0];
            want.loud     = (lvl > loud_db);
            want.overflow = too_long;
            levels_due.push_back(want);
            abs_sum  = '0;
            n_summed = 0;
            too_long = 1'b0;
        endfunction

        task report(string field, int got, int want);
            $display("%0t: %s mismatch, got %0d want %0d", $time, field, got, want);
            errors++;
        endtask

        task match_level(t_out_beat got);
            t_out_beat want;
            if (levels_due.size() == 0) begin
                report("unrequested beat level_db", got.level_db, 0);
                return;
            end
            want = levels_due.pop_front();
            if (got.level_db !== want.level_db) report("level_db", got.level_db, want.level_db);
            if (got.loud !== want.loud) report("loud", got.loud, want.loud);
            if (got.overflow !== want.overflow) report("overflow", got.overflow, want.overflow);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    t_in_beat    i_in_data;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_beat   o_out_data;
    logic        i_out_stall;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_data;

    level_tracker lt;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_cycles = 0;

    pcm_block_level_db_meter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // output side: check accepted beats, stall in bursts or for a long hold
    initial begin : out_side
        int stall_left;
        stall_left = 0;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) lt.match_level(o_out_data);
            if (hold_cycles != 0) begin
                stall_left  = hold_cycles;
                hold_cycles = 0;
            end else if (stall_left == 0 && rx_idle_pct != 0
                         && $urandom_range(0, 99) < rx_idle_pct) begin
                stall_left = $urandom_range(1, 13);
            end
            i_out_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
        end
    end

    task automatic send_sample(int s, bit last);
        t_in_beat b;
        b.sample = s[15:0];
        b.last   = last;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        lt.take_sample(b);
    endtask

    function automatic int rand_sample(int amp);
        int v;
        v = int'($urandom_range(0, 2 * amp)) - amp;
        if (v > 32767) v = 32767;
        return v;
    endfunction

    // blocks of silence, of full scale, or of noise at a random scale
    task automatic send_block(int len);
        int kind;
        int amp;
        kind = $urandom_range(0, 15);
        amp  = 1 << $urandom_range(0, 15);
        for (int i = 0; i < len; i++) begin
            case (kind)
                0:       send_sample(0, i == len - 1);
                1:       send_sample(-32768, i == len - 1);
                default: send_sample(rand_sample(amp), i == len - 1);
            endcase
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(1, 8);
        if (r < 9) return $urandom_range(9, 40);
        return $urandom_range(41, 150);
    endfunction

    // hold the input until every pending level is out and the block is idle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (lt.levels_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_threshold(int thr);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= thr[7:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        lt.loud_db = thr[7:0];
    endtask

    initial begin : stimulus
        int thr;
        int sent;
        int guard;
        lt = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-sample blocks: silence, full scale both ways, table edges
        send_sample(0, 1'b1);
        send_sample(-32768, 1'b1);
        send_sample(32767, 1'b1);
        send_sample(1, 1'b1);
        send_sample(2, 1'b1);
        send_sample(29274, 1'b1);
        send_sample(29273, 1'b1);
        send_sample(585, 1'b1);
        send_sample(656, 1'b1);
        // all-zero block, one whose mean truncates to zero, and a full-scale one
        send_sample(0, 1'b0);
        send_sample(0, 1'b0);
        send_sample(0, 1'b1);
        send_sample(-1, 1'b0);
        send_sample(1, 1'b0);
        send_sample(0, 1'b0);
        send_sample(1, 1'b1);
        send_sample(-32768, 1'b0);
        send_sample(-32768, 1'b0);
        send_sample(32767, 1'b1);

        for (int p = 0; p < 9; p++) begin
            case (p)
                0:       thr = -96;
                1:       thr = 0;
                2:       thr = -128;
                3:       thr = 127;
                4:       thr = -7;
                5:       thr = -6;
                6:       thr = int'($urandom_range(0, 96)) - 96;
                7:       thr = int'($urandom_range(0, 255)) - 128;
                default: thr = -40;
            endcase
            settle();
            write_threshold(thr);
            tx_idle_pct = (p == 8 || p == 2 || p % 3 == 1) ? 0 : 12;
            rx_idle_pct = (p == 8 || p % 4 == 3) ? 0 : 15;
            // long output hold while input keeps coming: block must back up
            if (p == 2) hold_cycles = 300;
            sent = 0;
            while (sent < 180) begin
                thr = pick_len();
                send_block(thr);
                sent += thr;
            end
        end

        i_in_valid <= 1'b0;
        guard = 0;
        while (lt.levels_due.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
        if (lt.levels_due.size() != 0)
            lt.report("missing beats, count", lt.levels_due.size(), 0);
        if (lt.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/pcmdb_pkg.sv
rtl/pcmdb_level_unit.sv
rtl/pcm_block_level_db_meter.sv
test/tb_pcm_block_level_db_meter.sv
